// ===== hdl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg: shared types and constants for the k-nearest scan
// Field widths, the request into the sorted set and the packed result item.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int SAMPLE_W = 16;               // Q4.12 sample
  localparam int DIST_W   = 48;               // squared distance, unsigned
  localparam int TAG_W    = 32;               // candidate identifier
  localparam int CNT_W    = 5;                // k, held count
  localparam int SQ_W     = 2 * (SAMPLE_W + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // One item entering the set stage
  typedef struct packed {
    logic              new_query;
    logic              last_sample;
    logic [DIST_W-1:0] sq_dist;
    logic [TAG_W-1:0]  tag;
  } kts_req_t;

  // Result item; first member sits in the top bits, so admitted is bit 0
  typedef struct packed {
    logic [CNT_W-1:0]  held_count;
    logic              set_full;
    logic [DIST_W-1:0] kth_dist;
    logic [DIST_W-1:0] candidate_dist;
    logic [TAG_W-1:0]  evicted_tag;
    logic              evicted_valid;
    logic              admitted;
  } kts_result_t;

endpackage

// ===== hdl/kts_sorted_set.sv =====
// ----------------------------------------------------------------------------
// kts_sorted_set: k-best set, sorted ascending, with a registered insert
// Parallel compare against every held entry, shift-insert, evict the worst.
// ----------------------------------------------------------------------------
module kts_sorted_set #(
  parameter int K_MAX = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  kts_pkg::kts_req_t         req,
  input  logic [kts_pkg::CNT_W-1:0] top_count,
  output kts_pkg::kts_result_t      res
);
  import kts_pkg::*;

  // k never exceeds what the 5-bit register can name
  localparam int K_CAP = (K_MAX > 31) ? 31 : K_MAX;

  logic [DIST_W-1:0] dist_r   [K_MAX];
  logic [TAG_W-1:0]  tag_r    [K_MAX];
  logic [DIST_W-1:0] dist_nxt [K_MAX];
  logic [TAG_W-1:0]  tag_nxt  [K_MAX];
  logic [CNT_W-1:0]  count_r;

  logic [CNT_W-1:0]  k_eff, cnt, cnt_m1, n_keep, cnt_new, cnt_new_m1;
  logic              has_room, beats, do_insert, full;
  logic [DIST_W-1:0] worst_d, kth_sel;
  logic [TAG_W-1:0]  worst_t;
  logic [K_MAX-1:0]  le;

  always_comb begin
    if (top_count == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(top_count) > K_CAP) begin
      k_eff = CNT_W'(K_CAP);
    end else begin
      k_eff = top_count;
    end

    cnt      = req.new_query ? '0 : count_r;
    cnt_m1   = cnt - CNT_W'(1);
    has_room = cnt < k_eff;

    worst_d = '0;
    worst_t = '0;
    for (int i = 0; i < K_MAX; i++) begin
      if (int'(cnt_m1) == i) begin
        worst_d = dist_r[i];
        worst_t = tag_r[i];
      end
    end

    // full set: worst drops out first, newcomer needs a strictly smaller distance
    beats     = req.sq_dist < worst_d;
    do_insert = has_room || beats;
    n_keep    = has_room ? cnt : cnt_m1;

    // ties stay ahead of the newcomer
    for (int i = 0; i < K_MAX; i++) begin
      le[i] = (int'(n_keep) > i) && (dist_r[i] <= req.sq_dist);
    end

    if (do_insert && !le[0]) begin
      dist_nxt[0] = req.sq_dist;
      tag_nxt[0]  = req.tag;
    end else begin
      dist_nxt[0] = dist_r[0];
      tag_nxt[0]  = tag_r[0];
    end
    for (int i = 1; i < K_MAX; i++) begin
      if (!do_insert || le[i]) begin
        dist_nxt[i] = dist_r[i];
        tag_nxt[i]  = tag_r[i];
      end else if (le[i-1]) begin
        dist_nxt[i] = req.sq_dist;
        tag_nxt[i]  = req.tag;
      end else begin
        dist_nxt[i] = dist_r[i-1];
        tag_nxt[i]  = tag_r[i-1];
      end
    end

    cnt_new    = has_room ? cnt + CNT_W'(1) : cnt;
    cnt_new_m1 = cnt_new - CNT_W'(1);
    full       = cnt_new >= k_eff;

    kth_sel = '0;
    for (int i = 0; i < K_MAX; i++) begin
      if (int'(cnt_new_m1) == i) begin
        kth_sel = dist_nxt[i];
      end
    end

    res.admitted       = do_insert;
    res.evicted_valid  = !has_room && beats;
    res.evicted_tag    = (!has_room && beats) ? worst_t : '0;
    res.candidate_dist = req.sq_dist;
    res.kth_dist       = full ? kth_sel : '0;
    res.set_full       = full;
    res.held_count     = cnt_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step && req.last_sample) begin
      count_r <= cnt_new;
    end else if (step && req.new_query) begin
      count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && req.last_sample) begin
      for (int i = 0; i < K_MAX; i++) begin
        dist_r[i] <= dist_nxt[i];
        tag_r[i]  <= tag_nxt[i];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_evict_implies_admit: assert property (@(posedge clk) disable iff (!rst_n)
    step && req.last_sample && res.evicted_valid |-> res.admitted)
    else $error("eviction without admission");

  a_count_nonzero_after_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    step && req.last_sample |=> count_r != '0)
    else $error("set empty after a finished candidate");

  a_kth_zero_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    step && req.last_sample && !res.set_full |-> res.kth_dist == '0)
    else $error("kth distance reported for a set that is not full");
`endif

endmodule

// ===== hdl/knn_topk_euclidean_scan.sv =====
// ----------------------------------------------------------------------------
// knn_topk_euclidean_scan: streaming k-nearest scan by squared distance
// Accumulates squared sample differences per candidate and keeps the k best.
// ----------------------------------------------------------------------------
// One item per clock sustained while the output accepts results. Each input
// item carries one query and one candidate sample; an item with tlast set
// closes the candidate and yields exactly one result item, other items yield
// none. Pipeline: input register, squarer (17x17), 48-bit saturating
// accumulator, then the sorted-set stage whose parallel compare-insert over
// the k-set sets the rate. tuser on input (new query) empties the kept set
// and the running sum ahead of that item's sample. k is written through the
// cfg channel; the user must write it only while idle, the block itself does
// not enforce this. 0 acts as 1 and values above K_MAX act as K_MAX.
module knn_topk_euclidean_scan #(
  parameter int K_MAX = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // query_sample[15:0], record_sample[31:16],
                                   // record_tag[63:32]
  input  logic         in_tlast,   // last_sample
  input  logic         in_tuser,   // new_query
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // admitted[0], evicted_valid[1],
                                   // evicted_tag[33:2], candidate_dist[81:34],
                                   // kth_dist[129:82], set_full[130],
                                   // held_count[135:131]
  // configuration: top_count
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);
  import kts_pkg::*;

  // stage 1: captured item
  logic                       s1_v_r, s1_nq_r, s1_last_r;
  logic signed [SAMPLE_W-1:0] s1_q_r, s1_rec_r;
  logic [TAG_W-1:0]           s1_tag_r;
  // stage 2: squared difference
  logic                       s2_v_r, s2_nq_r, s2_last_r;
  logic [SQ_W-1:0]            s2_sq_r;
  logic [TAG_W-1:0]           s2_tag_r;
  // stage 3: running sum up to and including this sample
  logic                       s3_v_r;
  kts_req_t                   s3_req_r;
  // accumulator and config
  logic [DIST_W-1:0]          accum_r, accum_nxt;
  logic [CNT_W-1:0]           top_count_r;
  // output register
  logic                       out_valid_r;
  kts_result_t                out_res_r;

  logic                       out_slot, leave3, ready3, ready2, move1, move2;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic [SQ_W-1:0]            sq;
  logic [DIST_W:0]            sum;
  logic [DIST_W-1:0]          acc_base, acc_sat;
  kts_result_t                set_res;

  // handshake chain; a non-last item in stage 3 needs no output slot
  assign out_slot  = !out_valid_r || out_tready;
  assign leave3    = s3_v_r && (!s3_req_r.last_sample || out_slot);
  assign ready3    = !s3_v_r || leave3;
  assign move2     = s2_v_r && ready3;
  assign ready2    = !s2_v_r || ready3;
  assign move1     = s1_v_r && ready2;
  assign in_tready = !s1_v_r || ready2;
  assign cfg_ready = 1'b1;

  // |q - r| fits 17 bits unsigned
  assign diff = {s1_q_r[SAMPLE_W-1], s1_q_r} - {s1_rec_r[SAMPLE_W-1], s1_rec_r};
  assign mag  = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
  assign sq   = SQ_W'(mag) * SQ_W'(mag);

  // saturating sum, restarted by a new query
  assign acc_base  = s2_nq_r ? '0 : accum_r;
  assign sum       = {1'b0, acc_base} + (DIST_W+1)'(s2_sq_r);
  assign acc_sat   = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign accum_nxt = s2_last_r ? '0 : acc_sat;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      accum_r     <= '0;
      top_count_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (ready2) begin
        s2_v_r <= move1;
      end
      if (ready3) begin
        s3_v_r <= move2;
      end
      if (move2) begin
        accum_r <= accum_nxt;
      end
      if (cfg_valid) begin
        top_count_r <= cfg_data;
      end
      if (leave3 && s3_req_r.last_sample) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_nq_r   <= in_tuser;
      s1_last_r <= in_tlast;
      s1_q_r    <= in_tdata[15:0];
      s1_rec_r  <= in_tdata[31:16];
      s1_tag_r  <= in_tdata[63:32];
    end
    if (ready2) begin
      s2_nq_r   <= s1_nq_r;
      s2_last_r <= s1_last_r;
      s2_sq_r   <= sq;
      s2_tag_r  <= s1_tag_r;
    end
    if (ready3) begin
      s3_req_r.new_query   <= s2_nq_r;
      s3_req_r.last_sample <= s2_last_r;
      s3_req_r.sq_dist     <= acc_sat;
      s3_req_r.tag         <= s2_tag_r;
    end
    if (leave3 && s3_req_r.last_sample) begin
      out_res_r <= set_res;
    end
  end

  kts_sorted_set #(
    .K_MAX (K_MAX)
  ) u_set (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (leave3),
    .req       (s3_req_r),
    .top_count (top_count_r),
    .res       (set_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

`ifndef NO_ASSERTIONS
  a_accum_clears_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    move2 && s2_last_r |=> accum_r == '0)
    else $error("running sum not cleared after a candidate");

  a_no_result_for_inner_item: assert property (@(posedge clk) disable iff (!rst_n)
    leave3 && !s3_req_r.last_sample && !out_valid_r |=> !out_valid_r)
    else $error("result raised for an item without last_sample");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && s2_v_r && s3_v_r && out_valid_r)
    else $error("input stalled with a free stage");
`endif

endmodule
